@@ hdl/k_way_sorted_merge_assert.svh @@
// Assertion macros used by the checker file of the k-way merger.
`ifndef K_WAY_SORTED_MERGE_ASSERT_SVH
`define K_WAY_SORTED_MERGE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define KWM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define KWM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/kwm_pkg.sv @@
// Types, constants and helpers shared by the k-way merger modules.
package kwm_pkg;

    localparam int LISTS       = 8;
    localparam int LIST_DEPTH  = 64;
    localparam int DATA_W      = 32;
    localparam int IDX_W       = $clog2(LISTS);
    localparam int TREE_LEAVES = 1 << IDX_W;
    localparam int PTR_W       = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W       = $clog2(LIST_DEPTH + 1);

    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    typedef enum logic [1:0] {
        ST_PUSHED  = 2'd0,
        ST_DROPPED = 2'd1,
        ST_POPPED  = 2'd2,
        ST_EMPTY   = 2'd3
    } status_t;

    // Per-list command for one cycle.
    typedef struct packed {
        logic push;
        logic pop;
    } lane_ctl_t;

    // Per-list state seen by the merge logic.
    typedef struct packed {
        logic                     vld;
        logic                     full;
        logic signed [DATA_W-1:0] head;
    } lane_stat_t;

    // One node of the minimum tree.
    typedef struct packed {
        logic                     vld;
        logic [IDX_W-1:0]         idx;
        logic signed [DATA_W-1:0] val;
    } node_t;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(LIST_DEPTH - 1))
            r = '0;
        else
            r = p + 1'b1;
        return r;
    endfunction

endpackage

@@ hdl/kwm_lane.sv @@
// One source list: FIFO storage with a registered head word.
module kwm_lane (
    input  logic                             clk,
    input  logic                             rst_n,
    input  kwm_pkg::lane_ctl_t               ctl,
    input  logic signed [kwm_pkg::DATA_W-1:0] wdata,
    output kwm_pkg::lane_stat_t              stat
);

    logic [kwm_pkg::DATA_W-1:0] mem [kwm_pkg::LIST_DEPTH];

    logic [kwm_pkg::PTR_W-1:0]  rptr_reg, rptr_next;
    logic [kwm_pkg::PTR_W-1:0]  wptr_reg, wptr_next;
    logic [kwm_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [kwm_pkg::DATA_W-1:0] head_reg;

    always_comb
    begin
        rptr_next = rptr_reg;
        wptr_next = wptr_reg;
        cnt_next  = cnt_reg;
        if (ctl.pop)
        begin
            rptr_next = kwm_pkg::next_slot(rptr_reg);
            cnt_next  = cnt_reg - 1'b1;
        end
        if (ctl.push)
        begin
            wptr_next = kwm_pkg::next_slot(wptr_reg);
            cnt_next  = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rptr_reg <= '0;
            wptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            rptr_reg <= rptr_next;
            wptr_reg <= wptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Head always tracks mem[rptr]; a push into an empty list bypasses the array.
    always_ff @(posedge clk)
    begin
        if (ctl.push)
            mem[wptr_reg] <= wdata;
        if (ctl.push && (wptr_reg == rptr_next))
            head_reg <= wdata;
        else
            head_reg <= mem[rptr_next];
    end

    assign stat.vld  = (cnt_reg != '0);
    assign stat.full = (cnt_reg == kwm_pkg::CNT_W'(kwm_pkg::LIST_DEPTH));
    assign stat.head = head_reg;

endmodule

@@ hdl/kwm_min_tree.sv @@
// Comparator tree picking the smallest valid head; ties go to the lower list.
module kwm_min_tree (
    input  kwm_pkg::lane_stat_t stat [kwm_pkg::LISTS],
    output kwm_pkg::node_t      win
);

    localparam int P = kwm_pkg::TREE_LEAVES;

    kwm_pkg::node_t node [1:2*P-1];

    function automatic kwm_pkg::node_t pick(input kwm_pkg::node_t l, input kwm_pkg::node_t r);
        kwm_pkg::node_t res;
        if (l.vld && (!r.vld || (l.val <= r.val)))
            res = l;
        else
            res = r;
        return res;
    endfunction

    for (genvar i = 0; i < P; i++)
    begin : g_leaf
        if (i < kwm_pkg::LISTS)
        begin : g_used
            assign node[P+i].vld = stat[i].vld;
            assign node[P+i].idx = kwm_pkg::IDX_W'(i);
            assign node[P+i].val = stat[i].head;
        end
        else
        begin : g_pad
            assign node[P+i] = '0;
        end
    end

    for (genvar n = 1; n < P; n++)
    begin : g_node
        assign node[n] = pick(node[2*n], node[2*n+1]);
    end

    assign win = node[1];

endmodule

@@ hdl/k_way_sorted_merge.sv @@
// K-way merger of ascending lists: per-list FIFOs, merged pop of the smallest head.
// Usage: takes one push or pop per cycle when not stalled and returns exactly one result
// for each, in order; a result is registered on the output after its item has passed the
// input register. The list heads sit in registers and feed a comparator tree, so the pop
// decision and the chosen list's head refill share a cycle: the rate is one item per cycle.
// Each list holds LIST_DEPTH words in its own RAM; a push to a full list, or to a list
// number at or above LISTS, is dropped. Equal heads go to the lowest list number.
module k_way_sorted_merge (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              kind,
    input  logic [2:0]                        list_index,
    input  logic signed [kwm_pkg::DATA_W-1:0] value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [1:0]                        status,
    output logic signed [kwm_pkg::DATA_W-1:0] merged_value,
    output logic [2:0]                        source_list
);

    logic                              in_vld_reg, in_vld_next;
    logic                              kind_reg;
    logic [2:0]                        idx_reg;
    logic signed [kwm_pkg::DATA_W-1:0] value_reg;

    logic                              out_vld_reg, out_vld_next;
    kwm_pkg::status_t                  status_reg, status_next;
    logic signed [kwm_pkg::DATA_W-1:0] merged_reg, merged_next;
    logic [2:0]                        src_reg, src_next;

    kwm_pkg::lane_ctl_t  ctl  [kwm_pkg::LISTS];
    kwm_pkg::lane_stat_t stat [kwm_pkg::LISTS];
    kwm_pkg::node_t      win;

    logic advance, fire, in_take, full_sel, in_range, push_ok;

    assign advance  = !out_vld_reg || !out_stall;
    assign fire     = in_vld_reg && advance;
    assign in_stall = in_vld_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    for (genvar i = 0; i < kwm_pkg::LISTS; i++)
    begin : g_lane
        kwm_lane u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .ctl   (ctl[i]),
            .wdata (value_reg),
            .stat  (stat[i])
        );
    end

    kwm_min_tree u_tree (
        .stat (stat),
        .win  (win)
    );

    always_comb
    begin
        full_sel = 1'b0;
        for (int i = 0; i < kwm_pkg::LISTS; i++)
        begin
            if (int'(idx_reg) == i)
                full_sel = stat[i].full;
        end
        in_range = (int'(idx_reg) < kwm_pkg::LISTS);
        push_ok  = in_range && !full_sel;

        for (int i = 0; i < kwm_pkg::LISTS; i++)
        begin
            ctl[i].push = fire && (kind_reg == kwm_pkg::KIND_PUSH) && push_ok
                          && (int'(idx_reg) == i);
            ctl[i].pop  = fire && (kind_reg == kwm_pkg::KIND_POP) && win.vld
                          && (win.idx == kwm_pkg::IDX_W'(i));
        end

        merged_next = '0;
        src_next    = '0;
        unique case (kind_reg)
            kwm_pkg::KIND_PUSH:
            begin
                status_next = push_ok ? kwm_pkg::ST_PUSHED : kwm_pkg::ST_DROPPED;
            end
            kwm_pkg::KIND_POP:
            begin
                if (win.vld)
                begin
                    status_next = kwm_pkg::ST_POPPED;
                    merged_next = win.val;
                    src_next    = 3'(win.idx);
                end
                else
                begin
                    status_next = kwm_pkg::ST_EMPTY;
                end
            end
            default:
            begin
                status_next = kwm_pkg::ST_EMPTY;
            end
        endcase

        if (in_take)
            in_vld_next = 1'b1;
        else if (fire)
            in_vld_next = 1'b0;
        else
            in_vld_next = in_vld_reg;

        if (fire)
            out_vld_next = 1'b1;
        else if (out_vld_reg && !out_stall)
            out_vld_next = 1'b0;
        else
            out_vld_next = out_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            kind_reg  <= kind;
            idx_reg   <= list_index;
            value_reg <= value;
        end
        if (fire)
        begin
            status_reg <= status_next;
            merged_reg <= merged_next;
            src_reg    <= src_next;
        end
    end

    assign out_valid    = out_vld_reg;
    assign status       = status_reg;
    assign merged_value = merged_reg;
    assign source_list  = src_reg;

endmodule

@@ hdl/kwm_checker.sv @@
// Port-level checks for the k-way merger, bound to the top level.
`include "k_way_sorted_merge_assert.svh"

module kwm_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_stall,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic [1:0]                        status,
    input logic signed [kwm_pkg::DATA_W-1:0] merged_value,
    input logic [2:0]                        source_list
);

    // Anything but a successful pop carries zero payload.
    `KWM_ASSERT_NOW(a_zero_payload, out_valid && (status != kwm_pkg::ST_POPPED), (merged_value == '0) && (source_list == '0), "non-pop result with nonzero payload")

    // Input only backs up when a finished result is held by the consumer.
    `KWM_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without output backpressure")

    // A held result keeps its contents.
    `KWM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(merged_value) && $stable(source_list), "stalled result changed")

endmodule

bind k_way_sorted_merge kwm_checker u_kwm_checker (.*);

@@ tb/testbench.sv @@
// Self-checking testbench for the k-way sorted merger: push/pop traffic, merge prediction.
module testbench;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 10;

    typedef struct packed {
        kwm_pkg::status_t                  st;
        logic signed [kwm_pkg::DATA_W-1:0] val;
        logic [2:0]                        src;
    } merge_result_t;

    logic                              clk        = 1'b0;
    logic                              rst_n      = 1'b0;
    logic                              in_valid   = 1'b0;
    logic                              kind       = kwm_pkg::KIND_PUSH;
    logic [2:0]                        list_index = '0;
    logic signed [kwm_pkg::DATA_W-1:0] value      = '0;
    logic                              out_stall  = 1'b0;
    logic                              in_stall;
    logic                              out_valid;
    logic [1:0]                        status;
    logic signed [kwm_pkg::DATA_W-1:0] merged_value;
    logic [2:0]                        source_list;

    k_way_sorted_merge uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .list_index   (list_index),
        .value        (value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .merged_value (merged_value),
        .source_list  (source_list)
    );

    // predicted per-list FIFOs
    logic signed [kwm_pkg::DATA_W-1:0] lane_mem [kwm_pkg::LISTS][kwm_pkg::LIST_DEPTH];
    int                                lane_rd  [kwm_pkg::LISTS];
    int                                lane_wr  [kwm_pkg::LISTS];
    int                                lane_cnt [kwm_pkg::LISTS];
    longint                            lane_last [kwm_pkg::LISTS];

    merge_result_t merge_results_due [$];
    merge_result_t due_r;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int idle_cycles   = 0;
    int fail_count    = 0;
    int push_total    = 0;
    int drop_total    = 0;
    int pop_total     = 0;
    int empty_total   = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Works out the result of one accepted item and updates the predicted lists.
    task automatic merge_predict(input logic k, input logic [2:0] li,
                                 input logic signed [kwm_pkg::DATA_W-1:0] v);
        merge_result_t r;
        int best;
        r.st  = kwm_pkg::ST_PUSHED;
        r.val = '0;
        r.src = '0;
        best  = -1;
        if (k == kwm_pkg::KIND_PUSH)
        begin
            if (int'(li) < kwm_pkg::LISTS && lane_cnt[li] < kwm_pkg::LIST_DEPTH)
            begin
                lane_mem[li][lane_wr[li]] = v;
                lane_wr[li]  = (lane_wr[li] + 1) % kwm_pkg::LIST_DEPTH;
                lane_cnt[li] = lane_cnt[li] + 1;
                push_total++;
            end
            else
            begin
                r.st = kwm_pkg::ST_DROPPED;
                drop_total++;
            end
        end
        else
        begin
            // strict less-than keeps the lowest list on equal heads
            for (int i = 0; i < kwm_pkg::LISTS; i++)
            begin
                if (lane_cnt[i] != 0)
                begin
                    if (best < 0 || lane_mem[i][lane_rd[i]] < lane_mem[best][lane_rd[best]])
                        best = i;
                end
            end
            if (best >= 0)
            begin
                r.st  = kwm_pkg::ST_POPPED;
                r.val = lane_mem[best][lane_rd[best]];
                r.src = best[2:0];
                lane_rd[best]  = (lane_rd[best] + 1) % kwm_pkg::LIST_DEPTH;
                lane_cnt[best] = lane_cnt[best] - 1;
                pop_total++;
            end
            else
            begin
                r.st = kwm_pkg::ST_EMPTY;
                empty_total++;
            end
        end
        merge_results_due = {merge_results_due, r};
    endtask

    // Offers one item, with a random gap first, and waits for its transfer.
    task automatic send_item(input logic k, input logic [2:0] li,
                             input logic signed [kwm_pkg::DATA_W-1:0] v);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        kind       <= k;
        list_index <= li;
        value      <= v;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        merge_predict(k, li, v);
    endtask

    // Next value for a list, ascending from the last one pushed; fresh start when empty.
    function automatic logic signed [kwm_pkg::DATA_W-1:0] next_sorted_value(input int lane);
        longint step;
        if (lane_cnt[lane] == 0)
        begin
            if ($urandom_range(0, 2) == 0)
                lane_last[lane] = longint'($urandom_range(0, 16)) - 8;
            else
                lane_last[lane] = longint'($signed($urandom()));
        end
        else
        begin
            step = longint'($urandom_range(0, 3) != 0) *
                   longint'($urandom_range(0, 1 << $urandom_range(0, 16)));
            lane_last[lane] = lane_last[lane] + step;
            if (lane_last[lane] > 64'sd2147483647)
                lane_last[lane] = 64'sd2147483647;
        end
        return lane_last[lane][kwm_pkg::DATA_W-1:0];
    endfunction

    task automatic send_pop();
        send_item(kwm_pkg::KIND_POP, 3'($urandom()), $urandom());
    endtask

    task automatic test_pop_when_empty();
        send_pop();
        send_pop();
    endtask

    task automatic test_extreme_values();
        send_item(kwm_pkg::KIND_PUSH, 3'd0, 32'sh7FFFFFFF);
        send_item(kwm_pkg::KIND_PUSH, 3'd7, 32'sh80000000);
        send_item(kwm_pkg::KIND_PUSH, 3'd3, 32'sd0);
        send_item(kwm_pkg::KIND_PUSH, 3'd4, -32'sd1);
        repeat (5) send_pop();
    endtask

    task automatic test_equal_heads();
        send_item(kwm_pkg::KIND_PUSH, 3'd6, 32'sd7);
        send_item(kwm_pkg::KIND_PUSH, 3'd2, 32'sd7);
        send_item(kwm_pkg::KIND_PUSH, 3'd5, 32'sd7);
        send_item(kwm_pkg::KIND_PUSH, 3'd0, 32'sd8);
        repeat (4) send_pop();
    endtask

    task automatic test_merge_traffic(input int count, input int push_pct);
        int lane;
        logic signed [kwm_pkg::DATA_W-1:0] v;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 99) < push_pct)
            begin
                lane = $urandom_range(0, 7);
                // one push in ten is out of order
                if ($urandom_range(0, 9) == 0)
                    v = $urandom();
                else
                    v = next_sorted_value(lane);
                send_item(kwm_pkg::KIND_PUSH, lane[2:0], v);
            end
            else
                send_pop();
        end
    endtask

    // Overfills two lists so pushes get dropped, then drains everything and pops past empty.
    task automatic test_full_lists();
        int lane_a;
        int lane_b;
        int lane;
        int held;
        lane_a = $urandom_range(0, 7);
        lane_b = (lane_a + $urandom_range(1, 7)) % 8;
        for (int n = 0; n < 150; n++)
        begin
            lane = $urandom_range(0, 1) ? lane_a : lane_b;
            send_item(kwm_pkg::KIND_PUSH, lane[2:0], next_sorted_value(lane));
        end
        held = 0;
        for (int i = 0; i < kwm_pkg::LISTS; i++)
            held += lane_cnt[i];
        repeat (held + 4) send_pop();
    endtask

    // Receiver holds off for a long stretch while items keep coming.
    task automatic test_output_backpressure();
        hold_requests++;
        test_merge_traffic(60, 60);
    endtask

    // result check and receiver stall
    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (merge_results_due.size() == 0)
            begin
                $display("%0t: unexpected result status %0d value %0d list %0d",
                         $time, status, merged_value, source_list);
                fail_count++;
            end
            else
            begin
                due_r = merge_results_due.pop_front();
                if (status !== due_r.st)
                begin
                    $display("%0t: status expected %0d got %0d", $time, due_r.st, status);
                    fail_count++;
                end
                if (merged_value !== due_r.val)
                begin
                    $display("%0t: merged_value expected %0d got %0d",
                             $time, due_r.val, merged_value);
                    fail_count++;
                end
                if (source_list !== due_r.src)
                begin
                    $display("%0t: source_list expected %0d got %0d",
                             $time, due_r.src, source_list);
                    fail_count++;
                end
            end
        end
        if (hold_seen != hold_requests)
        begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        else if (hold_left > 0)
            hold_left = hold_left - 1;
        out_stall <= (hold_left > 0) || ($urandom_range(0, 99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog, no transfer for %0d cycles", $time, idle_cycles);
            $display("testbench: errors");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < kwm_pkg::LISTS; i++)
        begin
            lane_rd[i]   = 0;
            lane_wr[i]   = 0;
            lane_cnt[i]  = 0;
            lane_last[i] = 0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 36;
        recv_idle_pct = 59;
        test_pop_when_empty();
        test_extreme_values();
        test_equal_heads();
        test_merge_traffic(380, 60);

        send_idle_pct = 59;
        recv_idle_pct = 36;
        test_merge_traffic(380, 45);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_full_lists();
        test_output_backpressure();
        test_merge_traffic(60, 50);
        in_valid <= 1'b0;

        while (merge_results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d pushes stored, %0d dropped on full lists, %0d merged pops,",
                 push_total, drop_total, pop_total);
        $display("%0d pops on empty lists, three idling mixes and a long output hold-off",
                 empty_total);
        if (fail_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
